@@ rtl/rpbu_pkg.sv @@
package rpbu_pkg;

    localparam logic [3:0] MODE_NONE     = 4'd0;
    localparam logic [3:0] MODE_SET      = 4'd1;
    localparam logic [3:0] MODE_MULTIPLY = 4'd2;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd3;
    localparam logic [3:0] MODE_DARKEN   = 4'd4;
    localparam logic [3:0] MODE_SCREEN   = 4'd5;
    localparam logic [3:0] MODE_DODGE    = 4'd6;
    localparam logic [3:0] MODE_CBURN    = 4'd7;
    localparam logic [3:0] MODE_ADD      = 4'd8;
    localparam logic [3:0] MODE_ADDA     = 4'd9;
    localparam logic [3:0] MODE_BURN     = 4'd10;
    localparam logic [3:0] MODE_OVERLAY  = 4'd11;
    localparam logic [3:0] MODE_ALPH     = 4'd12;
    localparam logic [3:0] MODE_DEFAULT  = 4'd13;

    localparam logic [7:0] CHAN_MAX     = 8'd255;
    localparam logic [7:0] OVERLAY_SPLIT = 8'd128;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } rsp_t;

    // how the final stage forms the channel, from the quotient or the direct value
    typedef enum logic [1:0] {
        POST_DIRECT,
        POST_SAT,
        POST_INV
    } post_t;

    typedef struct packed {
        post_t       post;
        logic [7:0]  direct;
        logic [15:0] num;
        logic [7:0]  den;
        logic [7:0]  rem;
        logic [8:0]  quo;
        logic        ovf;
    } chan_t;

endpackage

@@ rtl/rgb_pixel_blend_unit_core.sv @@
// Blends a source RGB pixel into a destination RGB pixel under one of the
// blend modes selected by cmd, one pixel per clock while the output is not
// stalled. Each channel has one 8x8 multiplier in the first stage and a
// pipelined restoring divider that resolves three quotient bits in each of
// the next three stages; the last stage saturates or inverts the quotient,
// or passes the direct value, into the result register.
// Both ports use valid/ready and a stall at the output only holds the
// stages that are occupied, so bubbles still close up behind it.
module rgb_pixel_blend_unit_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rpbu_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rpbu_pkg::rsp_t  rsp_data
);
    import rpbu_pkg::*;

    function automatic chan_t chan_prep(input logic [3:0] mode, input logic [7:0] d,
                                        input logic [7:0] s);
        chan_t       c;
        logic [7:0]  a;
        logic [7:0]  b;
        logic        sh;
        logic [8:0]  sum;
        logic [15:0] prod;
        c = '0;
        c.post = POST_DIRECT;
        c.direct = d;
        c.den = CHAN_MAX;
        a = '0;
        b = '0;
        sh = 1'b0;
        sum = {1'b0, d} + {1'b0, s};
        unique case (mode) inside
            MODE_SET:      c.direct = s;
            MODE_MULTIPLY:
            begin
                a = d;
                b = s;
                c.post = POST_SAT;
            end
            MODE_LIGHTEN:  c.direct = (d > s) ? d : s;
            MODE_DARKEN:   c.direct = (d < s) ? d : s;
            MODE_SCREEN:
            begin
                a = ~d;
                b = ~s;
                c.post = POST_INV;
            end
            MODE_DODGE:
            begin
                if (d != CHAN_MAX)
                begin
                    a = CHAN_MAX;
                    b = s;
                    c.den = ~d;
                    c.post = POST_SAT;
                end
            end
            MODE_CBURN:
            begin
                if (s != 8'd0)
                begin
                    a = CHAN_MAX;
                    b = ~d;
                    c.den = s;
                    c.post = POST_INV;
                end
            end
            MODE_ADD, MODE_ADDA:
                c.direct = sum[8] ? CHAN_MAX : sum[7:0];
            MODE_BURN:
                c.direct = (sum > {1'b0, CHAN_MAX}) ? 8'(sum - {1'b0, CHAN_MAX}) : 8'd0;
            MODE_OVERLAY:
            begin
                sh = 1'b1;
                if (s <= OVERLAY_SPLIT)
                begin
                    a = s;
                    b = d;
                    c.post = POST_SAT;
                end
                else
                begin
                    a = ~s;
                    b = ~d;
                    c.post = POST_INV;
                end
            end
            default:       c.direct = d;
        endcase
        prod = 16'(a) * 16'(b);
        c.num = sh ? {prod[14:0], 1'b0} : prod;
        return c;
    endfunction

    function automatic chan_t div_init(input chan_t c);
        chan_t r;
        r = c;
        r.ovf = ({1'b0, c.num[15:9]} >= c.den);
        r.rem = {1'b0, c.num[15:9]};
        r.quo = '0;
        return r;
    endfunction

    function automatic chan_t div3(input chan_t c, input logic [3:0] top);
        chan_t      r;
        logic [8:0] part;
        logic [3:0] idx;
        r = c;
        for (int k = 0; k < 3; k++)
        begin
            idx = top - 4'(k);
            part = {r.rem, r.num[idx]};
            if (part >= {1'b0, r.den})
            begin
                r.rem = 8'(part - {1'b0, r.den});
                r.quo = {r.quo[7:0], 1'b1};
            end
            else
            begin
                r.rem = part[7:0];
                r.quo = {r.quo[7:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] chan_post(input chan_t c);
        logic       big;
        logic [7:0] r;
        big = c.ovf | c.quo[8];
        case (c.post)
            POST_SAT: r = big ? CHAN_MAX : c.quo[7:0];
            POST_INV: r = big ? 8'd0 : ~c.quo[7:0];
            default:  r = c.direct;
        endcase
        return r;
    endfunction

    chan_t s1_reg [3];
    chan_t s2_reg [3];
    chan_t s3_reg [3];
    chan_t s4_reg [3];
    chan_t s1_next [3];
    chan_t s2_next [3];
    chan_t s3_next [3];
    chan_t s4_next [3];
    rsp_t  out_reg;
    rsp_t  out_next;
    logic  v1_reg;
    logic  v2_reg;
    logic  v3_reg;
    logic  v4_reg;
    logic  vo_reg;
    logic  adv1;
    logic  adv2;
    logic  adv3;
    logic  adv4;
    logic  adv_o;

    assign adv_o = !vo_reg || rsp_ready;
    assign adv4  = !v4_reg || adv_o;
    assign adv3  = !v3_reg || adv4;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign req_ready = adv1;

    always_comb
    begin
        s1_next[0] = chan_prep(req_data.cmd, req_data.dst_red, req_data.src_red);
        s1_next[1] = chan_prep(req_data.cmd, req_data.dst_green, req_data.src_green);
        s1_next[2] = chan_prep(req_data.cmd, req_data.dst_blue, req_data.src_blue);
        for (int i = 0; i < 3; i++)
        begin
            s2_next[i] = div3(div_init(s1_reg[i]), 4'd8);
            s3_next[i] = div3(s2_reg[i], 4'd5);
            s4_next[i] = div3(s3_reg[i], 4'd2);
        end
        out_next.out_red   = chan_post(s4_reg[0]);
        out_next.out_green = chan_post(s4_reg[1]);
        out_next.out_blue  = chan_post(s4_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= req_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv_o)
                vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= s1_next;
        if (adv2)
            s2_reg <= s2_next;
        if (adv3)
            s3_reg <= s3_next;
        if (adv4)
            s4_reg <= s4_next;
        if (adv_o)
            out_reg <= out_next;
    end

    assign rsp_valid = vo_reg;
    assign rsp_data  = out_reg;

    // a full pipe with a stalled result cannot take a new transfer
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg && !rsp_ready) |-> !req_ready)
        else $error("request taken into a full stalled pipe");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> v1_reg)
        else $error("accepted transfer did not reach the first stage");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(v4_reg))
        else $error("result appeared without an item in the last stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !v4_reg) |=> !rsp_valid)
        else $error("result repeated after transfer");

endmodule
